// ===== sv/sorted_wake_time_queue_macros.svh =====
// Assertion macros for the sorted wake-time queue.
// Used by the top level; no other dependencies.
`ifndef SORTED_WAKE_TIME_QUEUE_MACROS_SVH
`define SORTED_WAKE_TIME_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

`define SWTQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define SWTQ_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define SWTQ_ASSERT(lbl, clk, rst, prop, msg)

`define SWTQ_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== sv/swtq_pkg.sv =====
// Shared types and constants for the sorted wake-time queue.
// No dependencies.
`timescale 1ns / 1ps

package swtq_pkg;

   localparam int ID_W        = 6;
   localparam int TIME_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int MAX_RESULTS = 8;
   localparam int EMIT_CNT_W  = $clog2(MAX_RESULTS);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_WOKEN    = 2'd2,
      ST_NONE_DUE = 2'd3
   } status_type;

   typedef struct packed {
      logic insert;
      logic capture;
      logic pop;
   } dp_cmd_type;

   typedef struct packed {
      logic            full;
      logic            head_due;
      logic            next_due;
      logic [ID_W-1:0] head_id;
   } dp_stat_type;

endpackage

// ===== sv/swtq_channels.sv =====
// Request and response channel interfaces for the sorted wake-time queue.
// Depends on swtq_pkg.
`timescale 1ns / 1ps

interface swtq_req_if
   import swtq_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [ID_W-1:0]   proc_id;
   logic [TIME_W-1:0] time_stamp;

   modport source (output valid, cmd, proc_id, time_stamp, input ready);
   modport sink (input valid, cmd, proc_id, time_stamp, output ready);
endinterface

interface swtq_rsp_if
   import swtq_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     woken_id;
   logic                last;

   modport source (output valid, status, woken_id, last, input ready);
   modport sink (input valid, status, woken_id, last, output ready);
endinterface

// ===== sv/sorted_wake_time_queue.sv =====
// Sorted wake-time queue. Holds up to MAX_SLEEPERS process ids in ascending
// order of wake time, in a row of shifting cells. On an insert transaction
// every cell compares its time with the new one and the row opens a gap in
// place; the answer is inserted, or rejected when full. On a tick transaction
// the tick time is captured, then the head cell is compared and popped once
// per cycle while the response register is free, emitting one woken id a
// cycle (at most eight per tick) or a single nothing-due result. The
// controller takes no new transaction until a tick's last result is loaded
// into the response register, which holds while the response side stalls.
`timescale 1ns / 1ps
`include "sorted_wake_time_queue_macros.svh"

module sorted_wake_time_queue
   import swtq_pkg::*;
#(
   parameter int MAX_SLEEPERS = 8
) (
   input  logic       clock,
   input  logic       reset,
   swtq_req_if.sink   req_ch,
   swtq_rsp_if.source rsp_ch
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;
   status_type  rsp_status;
   logic        tick_accept;

   swtq_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_cmd      (req_ch.cmd),
      .req_ready    (req_ch.ready),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_status   (rsp_status),
      .rsp_woken_id (rsp_ch.woken_id),
      .rsp_last     (rsp_ch.last),
      .cmd          (dp_cmd),
      .stat         (dp_stat)
   );

   swtq_datapath #(
      .MAX_SLEEPERS (MAX_SLEEPERS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .req_proc_id    (req_ch.proc_id),
      .req_time_stamp (req_ch.time_stamp),
      .stat           (dp_stat)
   );

   assign rsp_ch.status = rsp_status;
   assign tick_accept   = req_ch.valid && req_ch.ready && (req_ch.cmd == CMD_TICK);

   `SWTQ_ASSERT_NEVER(a_insert_full, clock, reset, dp_cmd.insert && dp_stat.full, "insert when full")
   `SWTQ_ASSERT(a_pop_due, clock, reset, dp_cmd.pop |-> dp_stat.head_due, "pop of an entry not due")
   `SWTQ_ASSERT(a_tick_busy, clock, reset, tick_accept |=> !req_ch.ready, "ready during tick")

endmodule

// ===== sv/swtq_datapath.sv =====
// Sorted entry cells, occupancy count and captured tick time.
// Depends on swtq_pkg; driven by swtq_ctrl commands.
`timescale 1ns / 1ps

module swtq_datapath
   import swtq_pkg::*;
#(
   parameter int MAX_SLEEPERS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   input  logic [ID_W-1:0]   req_proc_id,
   input  logic [TIME_W-1:0] req_time_stamp,
   output dp_stat_type       stat
);

   localparam int CNT_W = $clog2(MAX_SLEEPERS + 1);

   logic [TIME_W-1:0] time_ff [MAX_SLEEPERS];
   logic [TIME_W-1:0] time_in [MAX_SLEEPERS];
   logic [ID_W-1:0]   id_ff   [MAX_SLEEPERS];
   logic [ID_W-1:0]   id_in   [MAX_SLEEPERS];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [TIME_W-1:0] tick_ff;
   logic [TIME_W-1:0] tick_in;
   logic [MAX_SLEEPERS-1:0] lt;

   always_comb begin
      for (int i = 0; i < MAX_SLEEPERS; i++) begin
         lt[i] = (CNT_W'(i) < count_ff) && (time_ff[i] < req_time_stamp);
      end
   end

   always_comb begin
      time_in  = time_ff;
      id_in    = id_ff;
      count_in = count_ff;
      tick_in  = tick_ff;
      if (cmd.insert) begin
         if (!lt[0]) begin
            time_in[0] = req_time_stamp;
            id_in[0]   = req_proc_id;
         end
         for (int i = 1; i < MAX_SLEEPERS; i++) begin
            if (!lt[i]) begin
               if (lt[i-1]) begin
                  time_in[i] = req_time_stamp;
                  id_in[i]   = req_proc_id;
               end else begin
                  time_in[i] = time_ff[i-1];
                  id_in[i]   = id_ff[i-1];
               end
            end
         end
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         for (int i = 0; i < MAX_SLEEPERS - 1; i++) begin
            time_in[i] = time_ff[i+1];
            id_in[i]   = id_ff[i+1];
         end
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.capture) begin
         tick_in = req_time_stamp;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      id_ff   <= id_in;
      tick_ff <= tick_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.full     = (count_ff == CNT_W'(MAX_SLEEPERS));
   assign stat.head_due = (count_ff != '0) && (time_ff[0] <= tick_ff);
   assign stat.head_id  = id_ff[0];

   generate
      if (MAX_SLEEPERS > 1) begin : g_next
         assign stat.next_due = (count_ff > CNT_W'(1)) && (time_ff[1] <= tick_ff);
      end else begin : g_single
         assign stat.next_due = 1'b0;
      end
   endgenerate

endmodule

// ===== sv/swtq_ctrl.sv =====
// Controller for the sorted wake-time queue: sequencing and response register.
// Depends on swtq_pkg; commands swtq_datapath.
`timescale 1ns / 1ps

module swtq_ctrl
   import swtq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_cmd,
   output logic            req_ready,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output status_type      rsp_status,
   output logic [ID_W-1:0] rsp_woken_id,
   output logic            rsp_last,
   output dp_cmd_type      cmd,
   input  dp_stat_type     stat
);

   typedef enum logic {
      S_IDLE,
      S_TICK
   } state_type;

   state_type             state_ff, state_in;
   logic                  valid_ff, valid_in;
   status_type            status_ff, status_in;
   logic [ID_W-1:0]       woken_id_ff, woken_id_in;
   logic                  last_ff, last_in;
   logic [EMIT_CNT_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic                  out_free;
   logic                  accept;
   logic                  final_wake;

   assign out_free   = !valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE) && out_free;
   assign accept     = req_valid && req_ready;
   assign final_wake = !stat.next_due || (emit_cnt_ff == EMIT_CNT_W'(MAX_RESULTS - 1));

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff && !rsp_ready;
      status_in   = status_ff;
      woken_id_in = woken_id_ff;
      last_in     = last_ff;
      emit_cnt_in = emit_cnt_ff;
      cmd         = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_INSERT) begin
                  valid_in    = 1'b1;
                  status_in   = stat.full ? ST_FULL : ST_INSERTED;
                  woken_id_in = '0;
                  last_in     = 1'b1;
                  cmd.insert  = !stat.full;
               end else begin
                  cmd.capture = 1'b1;
                  emit_cnt_in = '0;
                  state_in    = S_TICK;
               end
            end
         end
         S_TICK: begin
            if (out_free) begin
               valid_in = 1'b1;
               if (stat.head_due) begin
                  status_in   = ST_WOKEN;
                  woken_id_in = stat.head_id;
                  last_in     = final_wake;
                  cmd.pop     = 1'b1;
                  emit_cnt_in = emit_cnt_ff + EMIT_CNT_W'(1);
                  if (final_wake) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  status_in   = ST_NONE_DUE;
                  woken_id_in = '0;
                  last_in     = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      woken_id_ff <= woken_id_in;
      last_ff     <= last_in;
      if (reset) begin
         state_ff    <= S_IDLE;
         valid_ff    <= 1'b0;
         emit_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         emit_cnt_ff <= emit_cnt_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_woken_id = woken_id_ff;
   assign rsp_last     = last_ff;

endmodule

// ===== sim/tb_sorted_wake_time_queue.sv =====
// Self-checking testbench for the sorted wake-time queue: directed and random
// inserts and ticks under varied idling, checked against a behavioural model.
// Depends on swtq_pkg, swtq_channels and sorted_wake_time_queue.
`timescale 1ns / 1ps

module tb_sorted_wake_time_queue;
   import swtq_pkg::*;

   localparam int SLEEPERS       = 8;
   localparam int ITEMS_PER_PASS = 89;
   localparam int DRAIN_CYCLES   = 20;
   localparam int CYCLE_LIMIT    = 500000;

   typedef struct packed {
      status_type      status;
      logic [ID_W-1:0] woken_id;
      logic            last;
   } wake_result_type;

   class wake_scoreboard;
      logic [TIME_W-1:0] wake_time [SLEEPERS];
      logic [ID_W-1:0]   sleeper_id [SLEEPERS];
      int                held;
      wake_result_type   pending [$];
      int                errors;

      function new();
         held   = 0;
         errors = 0;
      endfunction

      function void note_request(logic cmd, logic [ID_W-1:0] id, logic [TIME_W-1:0] stamp);
         int              slot;
         int              due;
         int              i;
         wake_result_type res;
         res.woken_id = '0;
         res.last     = 1'b1;
         if (cmd == CMD_INSERT) begin
            if (held >= SLEEPERS) begin
               res.status = ST_FULL;
            end else begin
               slot = 0;
               while (slot < held && wake_time[slot] < stamp)
                  slot++;
               for (i = held; i > slot; i--) begin
                  wake_time[i]  = wake_time[i-1];
                  sleeper_id[i] = sleeper_id[i-1];
               end
               wake_time[slot]  = stamp;
               sleeper_id[slot] = id;
               held++;
               res.status = ST_INSERTED;
            end
            pending.push_back(res);
         end else begin
            due = 0;
            while (due < held && due < MAX_RESULTS && wake_time[due] <= stamp)
               due++;
            if (due == 0) begin
               res.status = ST_NONE_DUE;
               pending.push_back(res);
            end else begin
               res.status = ST_WOKEN;
               for (i = 0; i < due; i++) begin
                  res.woken_id = sleeper_id[i];
                  res.last     = (i == due - 1);
                  pending.push_back(res);
               end
               for (i = due; i < held; i++) begin
                  wake_time[i-due]  = wake_time[i];
                  sleeper_id[i-due] = sleeper_id[i];
               end
               held -= due;
            end
         end
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] id, logic last);
         wake_result_type want;
         if (pending.size() == 0) begin
            $error("unexpected result: status %0d woken_id %0d last %0d", status, id, last);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
         end
         if (id !== want.woken_id) begin
            $error("woken_id: expected %0d, got %0d", want.woken_id, id);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic           clock;
   logic           reset;
   int             send_idle_pct;
   int             stall_pct;
   int unsigned    cycle_count;
   wake_scoreboard wake_sb;

   swtq_req_if req_ch();
   swtq_rsp_if rsp_ch();

   sorted_wake_time_queue #(.MAX_SLEEPERS(SLEEPERS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // sample the response channel and randomise back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         wake_sb.check_result(rsp_ch.status, rsp_ch.woken_id, rsp_ch.last);
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_request(input logic cmd, input logic [ID_W-1:0] id,
                               input logic [TIME_W-1:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= cmd;
      req_ch.proc_id    <= id;
      req_ch.time_stamp <= stamp;
      do
         @(posedge clock);
      while (!(req_ch.valid && req_ch.ready));
      wake_sb.note_request(cmd, id, stamp);
   endtask

   initial begin
      logic [TIME_W-1:0] wall_time;
      logic [TIME_W-1:0] last_insert;
      logic [TIME_W-1:0] stamp;
      logic              cmd;
      int                roll;
      int                pass_idx;
      int                n;

      wake_sb           = new();
      send_idle_pct     = 0;
      stall_pct         = 0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.cmd        = CMD_INSERT;
      req_ch.proc_id    = '0;
      req_ch.time_stamp = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty queue, ordering of equal times, full store, batch wakes
      send_request(CMD_TICK, 6'd0, 32'h0000_0000);
      send_request(CMD_TICK, 6'd0, 32'hFFFF_FFFF);
      send_request(CMD_INSERT, 6'd63, 32'hFFFF_FFFF);
      send_request(CMD_INSERT, 6'd0, 32'h0000_0000);
      send_request(CMD_INSERT, 6'd5, 32'd100);
      send_request(CMD_INSERT, 6'd6, 32'd100);
      send_request(CMD_INSERT, 6'd7, 32'd100);
      send_request(CMD_INSERT, 6'd1, 32'd50);
      send_request(CMD_INSERT, 6'd2, 32'hFFFF_FFFF);
      send_request(CMD_INSERT, 6'd3, 32'h0000_0000);
      send_request(CMD_INSERT, 6'd9, 32'd10);
      send_request(CMD_TICK, 6'd0, 32'h0000_0000);
      send_request(CMD_TICK, 6'd0, 32'd99);
      send_request(CMD_TICK, 6'd0, 32'd100);
      send_request(CMD_TICK, 6'd0, 32'hFFFF_FFFE);
      send_request(CMD_TICK, 6'd0, 32'hFFFF_FFFF);
      for (n = 0; n < SLEEPERS; n++)
         send_request(CMD_INSERT, 6'(40 + n), 32'($urandom_range(1, 20)));
      send_request(CMD_TICK, 6'd0, 32'hFFFF_FFFF);

      wall_time   = '0;
      last_insert = '0;
      for (pass_idx = 0; pass_idx < 4; pass_idx++) begin
         case (pass_idx)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 78; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 78; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
         endcase
         for (n = 0; n < ITEMS_PER_PASS; n++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
               cmd   = 1'($urandom_range(1));
               stamp = $urandom();
            end else if (roll < 55) begin
               cmd = CMD_INSERT;
               if ($urandom_range(3) == 0)
                  stamp = last_insert;
               else
                  stamp = wall_time + $urandom_range(0, 150);
               last_insert = stamp;
            end else begin
               cmd       = CMD_TICK;
               wall_time = wall_time + $urandom_range(0, 100);
               stamp     = wall_time;
            end
            send_request(cmd, 6'($urandom_range(63)), stamp);
         end
      end
      req_ch.valid <= 1'b0;

      while (wake_sb.pending.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (wake_sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
